// ----- hdl/ucrh_pkg.sv -----
// Package with the shared types, codes and constants of the control endpoint handler.
package ucrh_pkg;

   localparam int MAX_PACKET = 64;

   localparam logic [55:0] CODING_DEFAULT = 56'h08_0000_0001_C200;

   typedef enum logic [1:0] {
      MODE_SETUP     = 2'd0,
      MODE_OUT_DATA  = 2'd1,
      MODE_IN_DONE   = 2'd2,
      MODE_BUS_RESET = 2'd3
   } mode_type;

   typedef enum logic [2:0] {
      RESP_NONE  = 3'd0,
      RESP_ZLP   = 3'd1,
      RESP_SEND  = 3'd2,
      RESP_STALL = 3'd3,
      RESP_ARM   = 3'd4
   } resp_type;

   typedef enum logic [2:0] {
      SRC_DEVICE   = 3'd0,
      SRC_CONFIG   = 3'd1,
      SRC_STRING0  = 3'd2,
      SRC_STRING1  = 3'd3,
      SRC_STRING2  = 3'd4,
      SRC_CODING   = 3'd5
   } source_type;

   typedef enum logic [1:0] {
      KIND_STANDARD = 2'd0,
      KIND_CLASS    = 2'd1,
      KIND_VENDOR   = 2'd2,
      KIND_RESERVED = 2'd3
   } kind_type;

   localparam logic [7:0] REQ_SET_ADDRESS      = 8'h05;
   localparam logic [7:0] REQ_GET_DESCRIPTOR   = 8'h06;
   localparam logic [7:0] REQ_SET_CONFIG       = 8'h09;
   localparam logic [7:0] REQ_SET_LINE_CODING  = 8'h20;
   localparam logic [7:0] REQ_GET_LINE_CODING  = 8'h21;
   localparam logic [7:0] REQ_SET_LINE_STATE   = 8'h22;

   localparam logic [7:0] DESC_DEVICE = 8'h01;
   localparam logic [7:0] DESC_CONFIG = 8'h02;
   localparam logic [7:0] DESC_STRING = 8'h03;

   localparam logic [7:0] STRING_INDEX_LAST = 8'd2;
   localparam logic [7:0] CONFIG_VALUE_ONE  = 8'd1;
   localparam logic [6:0] CODING_BYTES      = 7'd7;

   typedef struct packed {
      logic [1:0]  mode;
      logic [7:0]  request_type;
      logic [7:0]  request;
      logic [15:0] value;
      logic [15:0] length;
      logic [6:0]  out_count;
      logic [55:0] out_data;
   } req_item_type;

   typedef struct packed {
      logic [2:0]  response;
      logic [2:0]  data_source;
      logic [6:0]  send_length;
      logic [6:0]  device_address;
      logic        configured;
      logic        configure_endpoints;
      logic        dtr;
      logic        rts;
      logic [55:0] line_coding;
   } rsp_item_type;

   function automatic logic [6:0] source_length(input source_type src);
      logic [6:0] len;
      case (src)
         SRC_DEVICE:  len = 7'd18;
         SRC_CONFIG:  len = 7'd67;
         SRC_STRING0: len = 7'd4;
         SRC_STRING1: len = 7'd38;
         SRC_STRING2: len = 7'd24;
         SRC_CODING:  len = 7'd7;
         default:     len = 7'd0;
      endcase
      return len;
   endfunction

endpackage

// ----- hdl/ucrh_req_if.sv -----
// Interface of the event channel into the control endpoint handler.
interface ucrh_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  mode;
   logic [7:0]  request_type;
   logic [7:0]  request;
   logic [15:0] value;
   logic [15:0] length;
   logic [6:0]  out_count;
   logic [55:0] out_data;

   modport source (
      output valid, mode, request_type, request, value, length, out_count, out_data,
      input  ready
   );
   modport sink (
      input  valid, mode, request_type, request, value, length, out_count, out_data,
      output ready
   );
endinterface

// ----- hdl/ucrh_rsp_if.sv -----
// Interface of the result channel out of the control endpoint handler.
interface ucrh_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  response;
   logic [2:0]  data_source;
   logic [6:0]  send_length;
   logic [6:0]  device_address;
   logic        configured;
   logic        configure_endpoints;
   logic        dtr;
   logic        rts;
   logic [55:0] line_coding;

   modport source (
      output valid, response, data_source, send_length, device_address, configured,
             configure_endpoints, dtr, rts, line_coding,
      input  ready
   );
   modport sink (
      input  valid, response, data_source, send_length, device_address, configured,
             configure_endpoints, dtr, rts, line_coding,
      output ready
   );
endinterface

// ----- hdl/usb_control_request_handler_unit.sv -----
// Top level of the endpoint-0 control request handler with its device state.
// An accepted event is captured in the input register and its result beat in the result register.
// Throughput: one event per cycle while the result beat is not stalled, set by the
// single decode stage between the input register and the result register.
// Reset: synchronous and active high; it empties both stages and sets address 0,
// not configured, DTR and RTS low and the line coding to 115200 8N1.
module usb_control_request_handler_unit
   import ucrh_pkg::*;
(
   input logic       clock,
   input logic       reset,
   ucrh_req_if.sink  req_ch,
   ucrh_rsp_if.source rsp_ch
);

   logic         s1_valid_ff;
   req_item_type s1_item_ff;
   logic         rsp_valid_ff;
   rsp_item_type rsp_item_ff;
   rsp_item_type rsp_item_in;

   logic [6:0]  pending_address_ff, pending_address_in;
   logic        pending_valid_ff, pending_valid_in;
   logic [6:0]  applied_address_ff, applied_address_in;
   logic        configured_ff, configured_in;
   logic        dtr_ff, dtr_in;
   logic        rts_ff, rts_in;
   logic [55:0] coding_ff, coding_in;

   logic       s1_advance;
   logic       req_accept;
   mode_type   mode;
   kind_type   kind;
   resp_type   resp;
   source_type src;
   logic [6:0] src_len;
   logic [6:0] clamp_len;
   logic [6:0] send_len;
   logic       cfg_pulse;

   assign s1_advance    = s1_valid_ff && (!rsp_valid_ff || rsp_ch.ready);
   assign req_ch.ready  = !s1_valid_ff || s1_advance;
   assign req_accept    = req_ch.valid && req_ch.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_ch.ready) begin
         s1_valid_ff <= req_ch.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_item_ff.mode         <= req_ch.mode;
         s1_item_ff.request_type <= req_ch.request_type;
         s1_item_ff.request      <= req_ch.request;
         s1_item_ff.value        <= req_ch.value;
         s1_item_ff.length       <= req_ch.length;
         s1_item_ff.out_count    <= req_ch.out_count;
         s1_item_ff.out_data     <= req_ch.out_data;
      end
   end

   assign mode = mode_type'(s1_item_ff.mode);
   assign kind = kind_type'(s1_item_ff.request_type[6:5]);

   always_comb begin
      pending_address_in = pending_address_ff;
      pending_valid_in   = pending_valid_ff;
      applied_address_in = applied_address_ff;
      configured_in      = configured_ff;
      dtr_in             = dtr_ff;
      rts_in             = rts_ff;
      coding_in          = coding_ff;
      resp               = RESP_NONE;
      src                = SRC_DEVICE;
      cfg_pulse          = 1'b0;

      unique case (mode)
         MODE_SETUP: begin
            resp = RESP_STALL;
            if (kind == KIND_STANDARD) begin
               unique case (s1_item_ff.request)
                  REQ_SET_ADDRESS: begin
                     pending_address_in = s1_item_ff.value[6:0];
                     pending_valid_in   = 1'b1;
                     resp               = RESP_ZLP;
                  end
                  REQ_GET_DESCRIPTOR: begin
                     if (s1_item_ff.value[15:8] == DESC_DEVICE) begin
                        resp = RESP_SEND;
                        src  = SRC_DEVICE;
                     end else if (s1_item_ff.value[15:8] == DESC_CONFIG) begin
                        resp = RESP_SEND;
                        src  = SRC_CONFIG;
                     end else if (s1_item_ff.value[15:8] == DESC_STRING &&
                                  s1_item_ff.value[7:0] <= STRING_INDEX_LAST) begin
                        resp = RESP_SEND;
                        src  = source_type'(3'(SRC_STRING0) + s1_item_ff.value[2:0]);
                     end
                  end
                  REQ_SET_CONFIG: begin
                     if (s1_item_ff.value[7:0] == CONFIG_VALUE_ONE) begin
                        configured_in = 1'b1;
                        cfg_pulse     = 1'b1;
                     end
                     resp = RESP_ZLP;
                  end
                  default: begin
                     resp = RESP_STALL;
                  end
               endcase
            end else if (kind == KIND_CLASS) begin
               unique case (s1_item_ff.request)
                  REQ_SET_LINE_CODING: begin
                     resp = RESP_ARM;
                  end
                  REQ_GET_LINE_CODING: begin
                     resp = RESP_SEND;
                     src  = SRC_CODING;
                  end
                  REQ_SET_LINE_STATE: begin
                     dtr_in = s1_item_ff.value[0];
                     rts_in = s1_item_ff.value[1];
                     resp   = RESP_ZLP;
                  end
                  default: begin
                     resp = RESP_STALL;
                  end
               endcase
            end
         end
         MODE_OUT_DATA: begin
            if (s1_item_ff.out_count == CODING_BYTES) begin
               coding_in = s1_item_ff.out_data;
            end
            resp = RESP_ZLP;
         end
         MODE_IN_DONE: begin
            if (pending_valid_ff) begin
               applied_address_in = pending_address_ff;
               pending_address_in = 7'd0;
               pending_valid_in   = 1'b0;
            end
         end
         MODE_BUS_RESET: begin
            pending_address_in = 7'd0;
            pending_valid_in   = 1'b0;
            applied_address_in = 7'd0;
            configured_in      = 1'b0;
         end
         default: begin
            resp = RESP_NONE;
         end
      endcase
   end

   assign src_len   = source_length(src);
   assign clamp_len = (s1_item_ff.length < {9'd0, src_len}) ? s1_item_ff.length[6:0] : src_len;
   assign send_len  = (clamp_len > 7'(MAX_PACKET)) ? 7'(MAX_PACKET) : clamp_len;

   always_comb begin
      rsp_item_in.response            = resp;
      rsp_item_in.data_source         = (resp == RESP_SEND) ? src : SRC_DEVICE;
      rsp_item_in.send_length         = (resp == RESP_SEND) ? send_len : 7'd0;
      rsp_item_in.device_address      = applied_address_in;
      rsp_item_in.configured          = configured_in;
      rsp_item_in.configure_endpoints = cfg_pulse;
      rsp_item_in.dtr                 = dtr_in;
      rsp_item_in.rts                 = rts_in;
      rsp_item_in.line_coding         = coding_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_address_ff <= 7'd0;
         pending_valid_ff   <= 1'b0;
         applied_address_ff <= 7'd0;
         configured_ff      <= 1'b0;
         dtr_ff             <= 1'b0;
         rts_ff             <= 1'b0;
         coding_ff          <= CODING_DEFAULT;
      end else if (s1_advance) begin
         pending_address_ff <= pending_address_in;
         pending_valid_ff   <= pending_valid_in;
         applied_address_ff <= applied_address_in;
         configured_ff      <= configured_in;
         dtr_ff             <= dtr_in;
         rts_ff             <= rts_in;
         coding_ff          <= coding_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_advance) begin
         rsp_item_ff <= rsp_item_in;
      end
   end

   assign rsp_ch.valid               = rsp_valid_ff;
   assign rsp_ch.response            = rsp_item_ff.response;
   assign rsp_ch.data_source         = rsp_item_ff.data_source;
   assign rsp_ch.send_length         = rsp_item_ff.send_length;
   assign rsp_ch.device_address      = rsp_item_ff.device_address;
   assign rsp_ch.configured          = rsp_item_ff.configured;
   assign rsp_ch.configure_endpoints = rsp_item_ff.configure_endpoints;
   assign rsp_ch.dtr                 = rsp_item_ff.dtr;
   assign rsp_ch.rts                 = rsp_item_ff.rts;
   assign rsp_ch.line_coding         = rsp_item_ff.line_coding;

   // A beat that arms the data endpoints always reports the device as configured.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_item_ff.configure_endpoints) |-> rsp_item_ff.configured)
      else $error("Endpoint arm pulse without configured state.");

   // Only a data send carries a source and a length.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_item_ff.response != RESP_SEND) |->
         (rsp_item_ff.data_source == SRC_DEVICE && rsp_item_ff.send_length == 7'd0))
      else $error("Source or length set on a beat that sends no data.");

   // A send never exceeds one packet.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_item_ff.send_length <= 7'(MAX_PACKET)))
      else $error("Send length exceeds the packet size.");

   // A bus reset event leaves the device unaddressed and unconfigured.
   assert property (@(posedge clock) disable iff (reset)
      (s1_advance && mode == MODE_BUS_RESET) |=>
         (applied_address_ff == 7'd0 && !configured_ff && !pending_valid_ff))
      else $error("Bus reset did not clear the device state.");

   // Both stages are always empty right after reset.
   assert property (@(posedge clock) $past(reset) |-> (!s1_valid_ff && !rsp_valid_ff))
      else $error("Pipeline holds a beat after reset.");

endmodule

// ----- verif/tb.sv -----
// Self-checking testbench for the endpoint-0 control request handler.
`timescale 1ns / 1ps

module tb
   import ucrh_pkg::*;
();

   localparam int QUIET_LIMIT = 2000;
   localparam int HOLD_CYCLES = 300;
   localparam int RANDOM_ITEMS = 430;
   localparam int PAYLOAD_BYTES [6] = '{18, 67, 4, 38, 24, 7};

   localparam logic [7:0] REQ_GET_STATUS = 8'h00;
   localparam logic [7:0] REQ_UNDEFINED  = 8'hFF;
   localparam logic [7:0] DESC_UNKNOWN   = 8'h04;

   logic clock;
   logic reset;
   logic sink_hold = 1'b0;

   int send_idle_pct;
   int recv_idle_pct;
   int errors = 0;
   int items_sent = 0;
   int beats_checked = 0;
   int quiet_cycles = 0;

   logic [6:0]  dev_pending_addr;
   logic        dev_pending_valid;
   logic [6:0]  dev_address;
   logic        dev_configured;
   logic        dev_dtr;
   logic        dev_rts;
   logic [55:0] dev_coding;

   rsp_item_type awaited_answers [$];

   ucrh_req_if req_bus ();
   ucrh_rsp_if rsp_bus ();

   usb_control_request_handler_unit uut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_bus),
      .rsp_ch (rsp_bus)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic rsp_item_type answer_for(input req_item_type ev);
      rsp_item_type ans;
      kind_type     kind;
      source_type   src;
      int unsigned  n;
      logic         sending;
      ans = '0;
      src = SRC_DEVICE;
      sending = 1'b0;
      case (ev.mode)
         MODE_SETUP: begin
            kind = kind_type'(ev.request_type[6:5]);
            ans.response = RESP_STALL;
            if (kind == KIND_STANDARD) begin
               if (ev.request == REQ_SET_ADDRESS) begin
                  dev_pending_addr = ev.value[6:0];
                  dev_pending_valid = 1'b1;
                  ans.response = RESP_ZLP;
               end else if (ev.request == REQ_GET_DESCRIPTOR) begin
                  if (ev.value[15:8] == DESC_DEVICE) begin
                     sending = 1'b1;
                     src = SRC_DEVICE;
                  end else if (ev.value[15:8] == DESC_CONFIG) begin
                     sending = 1'b1;
                     src = SRC_CONFIG;
                  end else if (ev.value[15:8] == DESC_STRING &&
                               ev.value[7:0] <= STRING_INDEX_LAST) begin
                     sending = 1'b1;
                     case (ev.value[1:0])
                        2'd0: src = SRC_STRING0;
                        2'd1: src = SRC_STRING1;
                        default: src = SRC_STRING2;
                     endcase
                  end
               end else if (ev.request == REQ_SET_CONFIG) begin
                  if (ev.value[7:0] == CONFIG_VALUE_ONE) begin
                     dev_configured = 1'b1;
                     ans.configure_endpoints = 1'b1;
                  end
                  ans.response = RESP_ZLP;
               end
            end else if (kind == KIND_CLASS) begin
               if (ev.request == REQ_SET_LINE_CODING) begin
                  ans.response = RESP_ARM;
               end else if (ev.request == REQ_GET_LINE_CODING) begin
                  sending = 1'b1;
                  src = SRC_CODING;
               end else if (ev.request == REQ_SET_LINE_STATE) begin
                  dev_dtr = ev.value[0];
                  dev_rts = ev.value[1];
                  ans.response = RESP_ZLP;
               end
            end
            if (sending) begin
               ans.response = RESP_SEND;
               ans.data_source = src;
               n = PAYLOAD_BYTES[int'(src)];
               if (ev.length < n) n = ev.length;
               if (n > MAX_PACKET) n = MAX_PACKET;
               ans.send_length = 7'(n);
            end
         end
         MODE_OUT_DATA: begin
            if (ev.out_count == CODING_BYTES) dev_coding = ev.out_data;
            ans.response = RESP_ZLP;
         end
         MODE_IN_DONE: begin
            if (dev_pending_valid) begin
               dev_address = dev_pending_addr;
               dev_pending_addr = '0;
               dev_pending_valid = 1'b0;
            end
            ans.response = RESP_NONE;
         end
         default: begin
            dev_pending_addr = '0;
            dev_pending_valid = 1'b0;
            dev_address = '0;
            dev_configured = 1'b0;
            ans.response = RESP_NONE;
         end
      endcase
      ans.device_address = dev_address;
      ans.configured = dev_configured;
      ans.dtr = dev_dtr;
      ans.rts = dev_rts;
      ans.line_coding = dev_coding;
      return ans;
   endfunction

   function automatic req_item_type noise_event();
      req_item_type ev;
      logic [63:0]  wide;
      wide = {$urandom, $urandom};
      ev.mode = 2'($urandom_range(3));
      ev.request_type = 8'($urandom);
      ev.request = 8'($urandom);
      ev.value = 16'($urandom);
      ev.length = 16'($urandom);
      ev.out_count = 7'($urandom_range(64));
      ev.out_data = wide[55:0];
      return ev;
   endfunction

   function automatic req_item_type setup_event(input kind_type kind, input logic [7:0] code,
                                                input logic [15:0] value,
                                                input logic [15:0] length);
      req_item_type ev;
      ev = noise_event();
      ev.mode = MODE_SETUP;
      ev.request_type[6:5] = kind;
      ev.request = code;
      ev.value = value;
      ev.length = length;
      return ev;
   endfunction

   function automatic req_item_type flow_event(input mode_type m, input logic [6:0] count,
                                               input logic [55:0] data);
      req_item_type ev;
      ev = noise_event();
      ev.mode = m;
      ev.out_count = count;
      ev.out_data = data;
      return ev;
   endfunction

   function automatic logic [15:0] pick_length();
      case ($urandom_range(3))
         0: return 16'($urandom_range(0, 80));
         1: return 16'($urandom_range(0, 8));
         2: return 16'($urandom);
         default: return 16'hFFFF;
      endcase
   endfunction

   function automatic logic [15:0] pick_descriptor();
      logic [7:0] dtype;
      logic [7:0] idx;
      dtype = 8'($urandom_range(DESC_DEVICE, DESC_UNKNOWN));
      if ($urandom_range(9) == 0) dtype = 8'($urandom);
      idx = 8'($urandom_range(0, 3));
      if ($urandom_range(9) == 0) idx = 8'($urandom);
      return {dtype, idx};
   endfunction

   function automatic logic [55:0] random_bytes();
      logic [63:0] wide;
      wide = {$urandom, $urandom};
      return wide[55:0];
   endfunction

   function automatic req_item_type random_event();
      int unsigned roll;
      logic [6:0]  count;
      roll = $urandom_range(99);
      count = ($urandom_range(1) == 0) ? CODING_BYTES : 7'($urandom_range(64));
      if (roll < 15)
         return setup_event(KIND_STANDARD, REQ_GET_DESCRIPTOR, pick_descriptor(), pick_length());
      else if (roll < 25)
         return setup_event(KIND_STANDARD, REQ_SET_ADDRESS, 16'($urandom), pick_length());
      else if (roll < 38)
         return flow_event(MODE_IN_DONE, 7'($urandom_range(64)), random_bytes());
      else if (roll < 48)
         return setup_event(KIND_STANDARD, REQ_SET_CONFIG,
                            {8'($urandom), 8'($urandom_range(0, 2))}, pick_length());
      else if (roll < 55)
         return setup_event(KIND_CLASS, REQ_SET_LINE_CODING, 16'($urandom), pick_length());
      else if (roll < 65)
         return flow_event(MODE_OUT_DATA, count, random_bytes());
      else if (roll < 72)
         return setup_event(KIND_CLASS, REQ_GET_LINE_CODING, 16'($urandom), pick_length());
      else if (roll < 80)
         return setup_event(KIND_CLASS, REQ_SET_LINE_STATE, 16'($urandom), pick_length());
      else if (roll < 86)
         return flow_event(MODE_BUS_RESET, 7'($urandom_range(64)), random_bytes());
      return noise_event();
   endfunction

   task automatic send_event(input req_item_type ev);
      if ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_bus.valid <= 1'b1;
      req_bus.mode <= ev.mode;
      req_bus.request_type <= ev.request_type;
      req_bus.request <= ev.request;
      req_bus.value <= ev.value;
      req_bus.length <= ev.length;
      req_bus.out_count <= ev.out_count;
      req_bus.out_data <= ev.out_data;
      do @(posedge clock); while (!req_bus.ready);
      awaited_answers.push_back(answer_for(ev));
      items_sent++;
   endtask

   task automatic wait_for_answers();
      req_bus.valid <= 1'b0;
      do @(posedge clock); while (awaited_answers.size() != 0);
   endtask

   task automatic send_enumeration();
      logic [6:0] count;
      count = ($urandom_range(9) == 0) ? 7'($urandom_range(64)) : CODING_BYTES;
      send_event(flow_event(MODE_BUS_RESET, 7'($urandom_range(64)), random_bytes()));
      send_event(setup_event(KIND_STANDARD, REQ_GET_DESCRIPTOR, {DESC_DEVICE, 8'h00}, 16'd64));
      send_event(setup_event(KIND_STANDARD, REQ_SET_ADDRESS, 16'($urandom_range(127)), 16'd0));
      send_event(flow_event(MODE_IN_DONE, 7'($urandom_range(64)), random_bytes()));
      send_event(setup_event(KIND_STANDARD, REQ_GET_DESCRIPTOR, {DESC_CONFIG, 8'h00},
                             pick_length()));
      send_event(setup_event(KIND_STANDARD, REQ_GET_DESCRIPTOR,
                             {DESC_STRING, 8'($urandom_range(2))}, pick_length()));
      send_event(setup_event(KIND_STANDARD, REQ_SET_CONFIG, {8'h00, CONFIG_VALUE_ONE}, 16'd0));
      send_event(setup_event(KIND_CLASS, REQ_SET_LINE_CODING, 16'd0, 16'(CODING_BYTES)));
      send_event(flow_event(MODE_OUT_DATA, count, random_bytes()));
      send_event(setup_event(KIND_CLASS, REQ_SET_LINE_STATE, 16'($urandom_range(3)), 16'd0));
      send_event(setup_event(KIND_CLASS, REQ_GET_LINE_CODING, 16'd0, pick_length()));
   endtask

   task automatic test_descriptors();
      send_event(setup_event(KIND_STANDARD, REQ_GET_DESCRIPTOR, {DESC_DEVICE, 8'h00}, 16'hFFFF));
      send_event(setup_event(KIND_STANDARD, REQ_GET_DESCRIPTOR, {DESC_DEVICE, 8'hFF}, 16'd0));
      send_event(setup_event(KIND_STANDARD, REQ_GET_DESCRIPTOR, {DESC_CONFIG, 8'h00}, 16'hFFFF));
      send_event(setup_event(KIND_STANDARD, REQ_GET_DESCRIPTOR, {DESC_CONFIG, 8'h00}, 16'd63));
      send_event(setup_event(KIND_STANDARD, REQ_GET_DESCRIPTOR, {DESC_STRING, 8'd0}, 16'hFFFF));
      send_event(setup_event(KIND_STANDARD, REQ_GET_DESCRIPTOR, {DESC_STRING, 8'd1}, 16'd38));
      send_event(setup_event(KIND_STANDARD, REQ_GET_DESCRIPTOR, {DESC_STRING, STRING_INDEX_LAST},
                             16'd1));
      send_event(setup_event(KIND_STANDARD, REQ_GET_DESCRIPTOR,
                             {DESC_STRING, STRING_INDEX_LAST + 8'd1}, 16'hFFFF));
      send_event(setup_event(KIND_STANDARD, REQ_GET_DESCRIPTOR, {DESC_UNKNOWN, 8'h00}, 16'hFFFF));
      wait_for_answers();
   endtask

   task automatic test_address();
      send_event(setup_event(KIND_STANDARD, REQ_SET_ADDRESS, 16'hFFFF, 16'd0));
      send_event(flow_event(MODE_IN_DONE, 7'd0, 56'd0));
      send_event(flow_event(MODE_IN_DONE, 7'd64, {56{1'b1}}));
      send_event(setup_event(KIND_STANDARD, REQ_SET_ADDRESS, 16'h0000, 16'hFFFF));
      send_event(flow_event(MODE_IN_DONE, 7'd0, 56'd0));
      send_event(setup_event(KIND_STANDARD, REQ_SET_ADDRESS, 16'h0055, 16'd0));
      send_event(flow_event(MODE_BUS_RESET, 7'd0, 56'd0));
      send_event(flow_event(MODE_IN_DONE, 7'd0, 56'd0));
      wait_for_answers();
   endtask

   task automatic test_configuration();
      send_event(setup_event(KIND_STANDARD, REQ_SET_CONFIG, 16'hFF01, 16'd0));
      send_event(setup_event(KIND_STANDARD, REQ_SET_CONFIG, 16'h0002, 16'd0));
      send_event(flow_event(MODE_BUS_RESET, 7'd64, {56{1'b1}}));
      wait_for_answers();
   endtask

   task automatic test_line_coding();
      send_event(setup_event(KIND_CLASS, REQ_SET_LINE_CODING, 16'd0, 16'(CODING_BYTES)));
      send_event(flow_event(MODE_OUT_DATA, CODING_BYTES, {56{1'b1}}));
      send_event(setup_event(KIND_CLASS, REQ_GET_LINE_CODING, 16'd0, 16'hFFFF));
      send_event(flow_event(MODE_OUT_DATA, 7'd6, 56'd0));
      send_event(flow_event(MODE_OUT_DATA, 7'd64, 56'd0));
      send_event(flow_event(MODE_OUT_DATA, CODING_BYTES, 56'd0));
      send_event(setup_event(KIND_CLASS, REQ_GET_LINE_CODING, 16'd0, 16'd0));
      send_event(setup_event(KIND_CLASS, REQ_SET_LINE_STATE, 16'hFFFF, 16'd0));
      send_event(setup_event(KIND_CLASS, REQ_SET_LINE_STATE, 16'h0002, 16'd0));
      send_event(flow_event(MODE_BUS_RESET, 7'd0, 56'd0));
      wait_for_answers();
   endtask

   task automatic test_unknown_requests();
      send_event(setup_event(KIND_VENDOR, REQ_SET_ADDRESS, 16'h0011, 16'd0));
      send_event(setup_event(KIND_RESERVED, REQ_GET_DESCRIPTOR, {DESC_DEVICE, 8'h00}, 16'd64));
      send_event(setup_event(KIND_STANDARD, REQ_GET_STATUS, 16'd0, 16'd2));
      send_event(setup_event(KIND_CLASS, REQ_UNDEFINED, 16'hFFFF, 16'hFFFF));
      wait_for_answers();
   endtask

   task automatic test_random_traffic(input int sender_pct, input int receiver_pct);
      int start;
      send_idle_pct = sender_pct;
      recv_idle_pct = receiver_pct;
      start = items_sent;
      while (items_sent - start < RANDOM_ITEMS) begin
         if ($urandom_range(99) < 35)
            send_enumeration();
         else
            send_event(random_event());
      end
      wait_for_answers();
   endtask

   task automatic test_backpressure();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      fork
         begin
            sink_hold <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            sink_hold <= 1'b0;
         end
      join_none
      repeat (40) send_event(random_event());
      wait_for_answers();
   endtask

   task automatic compare_field(input string name, input logic [55:0] want,
                                input logic [55:0] got);
      if (got !== want) begin
         errors++;
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      end
   endtask

   always @(posedge clock) begin
      rsp_bus.ready <= !sink_hold && ($urandom_range(99) >= recv_idle_pct);
   end

   always @(posedge clock) begin : result_check
      rsp_item_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         beats_checked++;
         if (awaited_answers.size() == 0) begin
            errors++;
            $display("%0t: result beat with no event waiting, response %0h", $time,
                     rsp_bus.response);
         end else begin
            want = awaited_answers.pop_front();
            compare_field("response", want.response, rsp_bus.response);
            compare_field("data_source", want.data_source, rsp_bus.data_source);
            compare_field("send_length", want.send_length, rsp_bus.send_length);
            compare_field("device_address", want.device_address, rsp_bus.device_address);
            compare_field("configured", want.configured, rsp_bus.configured);
            compare_field("configure_endpoints", want.configure_endpoints,
                          rsp_bus.configure_endpoints);
            compare_field("dtr", want.dtr, rsp_bus.dtr);
            compare_field("rts", want.rts, rsp_bus.rts);
            compare_field("line_coding", want.line_coding, rsp_bus.line_coding);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("%0t: no beat moved for %0d cycles, %0d results outstanding", $time,
                  quiet_cycles, awaited_answers.size());
         $display("Test completed with failures");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      reset = 1'b1;
      send_idle_pct = 21;
      recv_idle_pct = 82;
      req_bus.valid = 1'b0;
      req_bus.mode = MODE_SETUP;
      req_bus.request_type = '0;
      req_bus.request = '0;
      req_bus.value = '0;
      req_bus.length = '0;
      req_bus.out_count = '0;
      req_bus.out_data = '0;
      dev_pending_addr = '0;
      dev_pending_valid = 1'b0;
      dev_address = '0;
      dev_configured = 1'b0;
      dev_dtr = 1'b0;
      dev_rts = 1'b0;
      dev_coding = CODING_DEFAULT;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      test_descriptors();
      test_address();
      test_configuration();
      test_line_coding();
      test_unknown_requests();
      test_random_traffic(21, 82);
      test_random_traffic(82, 21);
      test_random_traffic(0, 0);
      test_backpressure();

      wait_for_answers();
      repeat (8) @(posedge clock);
      if (awaited_answers.size() != 0) begin
         $display("%0t: %0d results never arrived", $time, awaited_answers.size());
      end
      $display("Sent %0d endpoint-0 events and checked %0d result beats, %0d errors.",
               items_sent, beats_checked, errors);
      $display("Covered descriptors, addressing, configuration, CDC requests, bus reset, stalls.");
      if (errors == 0 && awaited_answers.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
